// File: src/stable_priority_event_queue_unit_defines.svh
// Assertion macros shared by the stable priority event queue checkers.
// Depends on nothing; included by the checker module only.
`ifndef STABLE_PRIORITY_EVENT_QUEUE_UNIT_DEFINES_SVH
`define STABLE_PRIORITY_EVENT_QUEUE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPEQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("speq check failed: same-cycle rule");

// The consequent must hold in the cycle after the antecedent.
`define SPEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("speq check failed: next-cycle rule");

`endif

// File: src/speq_pkg.sv
// Types and constants of the stable priority event queue.
// Depends on nothing; imported by every module of the block.
package speq_pkg;

  localparam int KIND_W      = 3;
  localparam int PAYLOAD_W   = 32;
  localparam int TIME_W      = 32;
  localparam int RANK_W      = 8;
  localparam int FILL_W      = 5;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;

  localparam logic MODE_POST = 1'b0;
  localparam logic MODE_GET  = 1'b1;

  typedef struct packed {
    logic [RANK_W-1:0]    rank;
    logic [KIND_W-1:0]    kind;
    logic [PAYLOAD_W-1:0] payload;
    logic [TIME_W-1:0]    stamp;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } nbr_t;

  typedef struct packed {
    logic   post;
    logic   pop;
    entry_t new_entry;
  } cell_op_t;

endpackage

// File: src/speq_cell.sv
// One slot of the sorted event chain: holds an entry and moves data with its neighbors.
// Depends on speq_pkg.
module speq_cell
  import speq_pkg::*;
(
  input  logic     clk,
  input  cell_op_t op,
  input  logic     own_valid,
  input  nbr_t     prev,
  input  entry_t   below,
  output entry_t   entry
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   ins_here;
  logic   shift_here;

  // The chain is sorted by rank, highest first and oldest first among equals,
  // so a new event lands just behind the last entry whose rank is not lower.
  always_comb begin
    ins_here   = op.post && prev.valid && (prev.entry.rank >= op.new_entry.rank) &&
                 (!own_valid || (entry_r.rank < op.new_entry.rank));
    shift_here = op.post && prev.valid && (prev.entry.rank < op.new_entry.rank);
    entry_nxt  = entry_r;
    if (op.pop) begin
      entry_nxt = below;
    end else if (ins_here) begin
      entry_nxt = op.new_entry;
    end else if (shift_here) begin
      entry_nxt = prev.entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// File: src/stable_priority_event_queue_unit.sv
// Result: an accepted request's result is registered and shown in the next cycle.
// Throughput: one request per cycle while results are taken; every slot compares
// its rank with the broadcast request and shifts in the same cycle.
// Reset (rst_n low, synchronous) empties the queue and the output register at once;
// there is no clearing pass. Slot contents stay undefined until written.
module stable_priority_event_queue_unit
  import speq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
)(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata from bit 0: event_kind[2:0], payload[31:0], rank[7:0], time_now[31:0], zeros.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: mode (0 post, 1 get).
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata from bit 0: out_kind[2:0], out_payload[31:0], out_time[31:0],
  // out_rank[7:0], fill_level[4:0].
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: ok.
  output logic                   out_tuser
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic              ok_r;
  entry_t            res_r;
  logic [FILL_W-1:0] fill_r;

  logic              accept;
  logic              full;
  logic              empty;
  cell_op_t          op;
  entry_t            cell_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occ;
  entry_t            head_guard;

  assign accept = in_tvalid && in_tready;
  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_r == '0);

  always_comb begin
    op.new_entry.kind    = in_tdata[2:0];
    op.new_entry.payload = in_tdata[34:3];
    op.new_entry.rank    = in_tdata[42:35];
    op.new_entry.stamp   = in_tdata[74:43];
    op.post              = accept && (in_tuser == MODE_POST) && !full;
    op.pop               = accept && (in_tuser == MODE_GET) && !empty;
    head_guard           = '0;
    head_guard.rank      = '1;
  end

  always_comb begin
    count_nxt = count_r;
    if (op.post) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (op.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    nbr_t   prev_n;
    entry_t below_n;

    assign occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign prev_n = '{valid: 1'b1, entry: head_guard};
    end else begin : g_inner
      assign prev_n = '{valid: occ[i-1], entry: cell_q[i-1]};
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign below_n = cell_q[i];
    end else begin : g_mid
      assign below_n = cell_q[i+1];
    end

    speq_cell u_cell (
      .clk       (clk),
      .op        (op),
      .own_valid (occ[i]),
      .prev      (prev_n),
      .below     (below_n),
      .entry     (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r   <= op.post || op.pop;
      res_r  <= op.pop ? cell_q[0] : '0;
      fill_r <= FILL_W'(count_nxt);
    end
  end

  assign in_tready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = ok_r;
  assign out_tdata  = {fill_r, res_r.rank, res_r.stamp, res_r.payload, res_r.kind};

endmodule

// File: src/speq_checker.sv
// Port-level checks for the stable priority event queue, bound to the top level.
// Depends on speq_pkg and stable_priority_event_queue_unit_defines.svh.
`include "stable_priority_event_queue_unit_defines.svh"

module speq_checker
  import speq_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  `SPEQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  `SPEQ_ASSERT_NEXT(a_result_follows, clk, rst_n, in_tvalid && in_tready, out_tvalid)

  `SPEQ_ASSERT_SAME(a_room_when_idle, clk, rst_n, !out_tvalid, in_tready)

  `SPEQ_ASSERT_SAME(a_failed_is_blank, clk, rst_n, out_tvalid && !out_tuser,
                    out_tdata[74:0] == '0)

endmodule

bind stable_priority_event_queue_unit speq_checker u_speq_checker (.*);
